### design/lase_pkg.sv
`timescale 1ns / 1ps

package lase_pkg;

    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;

    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int COL_W = $clog2(MAX_COLS);
    localparam int CFG_W = 7;
    localparam int OP_W  = 2;
    // sweep counter runs up to rows + 2
    localparam int CNT_W = $clog2(MAX_ROWS + 3);

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'd1;

    localparam logic [OP_W-1:0] OP_SET  = 2'd0;
    localparam logic [OP_W-1:0] OP_GEN  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ = 2'd2;

    localparam logic [3:0] BIRTH_CNT   = 4'd3;
    localparam logic [3:0] SURVIVE_CNT = 4'd2;

    typedef logic [MAX_COLS-1:0] row_bits_t;

    typedef struct packed {
        logic             rd_en;
        logic [ROW_W-1:0] rd_addr;
        logic             wr_en;
        logic [ROW_W-1:0] wr_addr;
        row_bits_t        wr_data;
    } mem_req_t;

endpackage

### design/lase_in_if.sv
`timescale 1ns / 1ps

interface lase_in_if
    import lase_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [OP_W-1:0] opcode;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;

    modport source (output valid, output opcode, output row, output col, input ready);
    modport sink   (input valid, input opcode, input row, input col, output ready);
endinterface

### design/lase_out_if.sv
`timescale 1ns / 1ps

interface lase_out_if
    import lase_pkg::*;
();
    logic            valid;
    logic            ready;
    logic            cell_alive;
    logic [OP_W-1:0] done_opcode;

    modport source (output valid, output cell_alive, output done_opcode, input ready);
    modport sink   (input valid, input cell_alive, input done_opcode, output ready);
endinterface

### design/lase_grid_mem.sv
`timescale 1ns / 1ps

module lase_grid_mem
    import lase_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  mem_req_t  req,
    output row_bits_t rd_data
);

    row_bits_t               mem [MAX_ROWS];
    row_bits_t               rd_data_reg;
    logic [MAX_ROWS-1:0]     vld_reg;
    logic                    rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    // rows never written since reset read as dead
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                vld_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_vld_reg <= vld_reg[req.rd_addr];
            end
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

### design/lase_row_unit.sv
`timescale 1ns / 1ps

module lase_row_unit
    import lase_pkg::*;
(
    input  row_bits_t        up,
    input  row_bits_t        mid,
    input  row_bits_t        down,
    input  logic [CFG_W-1:0] cols,
    input  logic             h_one,
    output row_bits_t        nxt
);

    logic             w_one;
    logic             hw_one;
    logic [COL_W-1:0] last_col;

    assign w_one    = (cols == CFG_W'(1));
    assign hw_one   = h_one & w_one;
    assign last_col = COL_W'(cols - CFG_W'(1));

    genvar c;
    generate
        for (c = 0; c < MAX_COLS; c++)
        begin : g_col
            logic       l_up, l_mid, l_dn;
            logic       r_up, r_mid, r_dn;
            logic [7:0] nb;
            logic [3:0] n;
            logic       in_use;

            if (c == 0)
            begin : g_left_wrap
                assign l_up  = up[last_col];
                assign l_mid = mid[last_col];
                assign l_dn  = down[last_col];
            end
            else
            begin : g_left
                assign l_up  = up[c-1];
                assign l_mid = mid[c-1];
                assign l_dn  = down[c-1];
            end

            if (c < MAX_COLS - 1)
            begin : g_right
                logic wrap;
                assign wrap  = (CFG_W'(c + 1) >= cols);
                assign r_up  = wrap ? up[0]   : up[c+1];
                assign r_mid = wrap ? mid[0]  : mid[c+1];
                assign r_dn  = wrap ? down[0] : down[c+1];
            end
            else
            begin : g_right_wrap
                assign r_up  = up[0];
                assign r_mid = mid[0];
                assign r_dn  = down[0];
            end

            // offsets that land back on the cell itself drop out on tiny boards
            assign nb = {l_up & ~hw_one, up[c] & ~h_one, r_up & ~hw_one,
                         l_mid & ~w_one, r_mid & ~w_one,
                         l_dn & ~hw_one, down[c] & ~h_one, r_dn & ~hw_one};
            assign n      = 4'($countones(nb));
            assign in_use = (CFG_W'(c) < cols);
            assign nxt[c] = in_use ? ((n == BIRTH_CNT) | (mid[c] & (n == SURVIVE_CNT)))
                                   : mid[c];
        end
    endgenerate

endmodule

### design/life_automaton_step_engine_core.sv
`timescale 1ns / 1ps

// Toroidal B3/S23 life engine on a board of up to 64 x 64 cells.
// req carries one command word: opcode (set cell alive, advance one
// generation, read cell), row and col. rsp returns one word per command:
// cell_alive (read result, else 0) and done_opcode (echo of the opcode).
// rows_in_use / cols_in_use are written through cfg_we/cfg_index/cfg_data;
// the user must write them only while the engine is idle, which the block
// itself does not enforce. 0 acts as 1 and values above 64 act as 64.
// One command at a time: req.ready is high only while idle. Set and read
// go from accept to the response register through read of the row, update
// or bit pick, and load. A generation sweeps the board once through a
// single row update unit with a three-row window, bound by the one read
// port of the board memory. The next command is taken in the cycle after
// the response loads.
// A finished response waits in the output register until rsp.ready; the
// engine accepts the next command meanwhile and stalls in its last step
// only if that response is still not taken.
// Reset clears the board to all dead (per-row valid bits) and sets both
// dimensions to 64; no clearing pass is needed.
module life_automaton_step_engine_core
    import lase_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    lase_in_if.sink              req,
    lase_out_if.source           rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_CELL_RD = 3'd1;
    localparam logic [2:0] ST_CELL_WB = 3'd2;
    localparam logic [2:0] ST_GEN     = 3'd3;
    localparam logic [2:0] ST_DONE    = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [CFG_W-1:0] rows_reg, rows_next;
    logic [CFG_W-1:0] cols_reg, cols_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             rsp_valid_reg, rsp_valid_next;

    logic [OP_W-1:0]  op_reg, op_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic             alive_reg, alive_next;
    row_bits_t        up_reg, up_next;
    row_bits_t        mid_reg, mid_next;
    row_bits_t        row0_reg, row0_next;
    logic             rsp_alive_reg, rsp_alive_next;
    logic [OP_W-1:0]  rsp_op_reg, rsp_op_next;

    mem_req_t         mreq;
    row_bits_t        mem_rd_data;
    row_bits_t        down_row;
    row_bits_t        new_row;
    logic             in_board;
    logic             h_one;
    logic             gen_last;
    logic [CNT_W-1:0] rows_cnt;
    logic [CFG_W-1:0] cfg_eff_rows;
    logic [CFG_W-1:0] cfg_eff_cols;

    lase_grid_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mreq),
        .rd_data (mem_rd_data)
    );

    lase_row_unit u_row (
        .up    (up_reg),
        .mid   (mid_reg),
        .down  (down_row),
        .cols  (cols_reg),
        .h_one (h_one),
        .nxt   (new_row)
    );

    assign h_one    = (rows_reg == CFG_W'(1));
    assign rows_cnt = CNT_W'(rows_reg);
    assign gen_last = (cnt_reg == rows_cnt + CNT_W'(2));
    assign down_row = gen_last ? row0_reg : mem_rd_data;
    assign in_board = (CFG_W'(row_reg) < rows_reg) && (CFG_W'(col_reg) < cols_reg);

    assign cfg_eff_rows = (cfg_data == '0) ? CFG_W'(1) :
                          (cfg_data > CFG_W'(MAX_ROWS)) ? CFG_W'(MAX_ROWS) : cfg_data;
    assign cfg_eff_cols = (cfg_data == '0) ? CFG_W'(1) :
                          (cfg_data > CFG_W'(MAX_COLS)) ? CFG_W'(MAX_COLS) : cfg_data;

    assign req.ready       = (state_reg == ST_IDLE);
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.cell_alive  = rsp_alive_reg;
    assign rsp.done_opcode = rsp_op_reg;

    always_comb
    begin
        state_next     = state_reg;
        rows_next      = rows_reg;
        cols_next      = cols_reg;
        cnt_next       = cnt_reg;
        rsp_valid_next = rsp_valid_reg & ~rsp.ready;
        op_next        = op_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        alive_next     = alive_reg;
        up_next        = up_reg;
        mid_next       = mid_reg;
        row0_next      = row0_reg;
        rsp_alive_next = rsp_alive_reg;
        rsp_op_next    = rsp_op_reg;
        mreq           = '0;

        if (cfg_we)
        begin
            case (cfg_index)
                CFG_ROWS: rows_next = cfg_eff_rows;
                CFG_COLS: cols_next = cfg_eff_cols;
                default:  ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    op_next    = req.opcode;
                    row_next   = req.row;
                    col_next   = req.col;
                    alive_next = 1'b0;
                    cnt_next   = '0;
                    case (req.opcode)
                        OP_SET, OP_READ: state_next = ST_CELL_RD;
                        OP_GEN:          state_next = ST_GEN;
                        default:         state_next = ST_DONE;
                    endcase
                end
            end

            ST_CELL_RD:
            begin
                mreq.rd_en   = 1'b1;
                mreq.rd_addr = row_reg;
                state_next   = ST_CELL_WB;
            end

            ST_CELL_WB:
            begin
                if (in_board && (op_reg == OP_SET))
                begin
                    mreq.wr_en   = 1'b1;
                    mreq.wr_addr = row_reg;
                    mreq.wr_data = mem_rd_data | (row_bits_t'(1) << col_reg);
                end
                if (in_board && (op_reg == OP_READ))
                begin
                    alive_next = mem_rd_data[col_reg];
                end
                state_next = ST_DONE;
            end

            ST_GEN:
            begin
                // reads: last row first (upper wrap), then rows 0 .. last
                if (cnt_reg <= rows_cnt)
                begin
                    mreq.rd_en   = 1'b1;
                    mreq.rd_addr = (cnt_reg == '0) ? ROW_W'(rows_reg - CFG_W'(1))
                                                   : ROW_W'(cnt_reg - CNT_W'(1));
                end
                if (gen_last)
                begin
                    // last row wraps down onto the saved old row 0
                    mreq.wr_en   = 1'b1;
                    mreq.wr_addr = ROW_W'(rows_reg - CFG_W'(1));
                    mreq.wr_data = new_row;
                    state_next   = ST_DONE;
                end
                else
                begin
                    if (cnt_reg != '0)
                    begin
                        if (cnt_reg == CNT_W'(2))
                        begin
                            row0_next = mem_rd_data;
                        end
                        if (cnt_reg >= CNT_W'(3))
                        begin
                            mreq.wr_en   = 1'b1;
                            mreq.wr_addr = ROW_W'(cnt_reg - CNT_W'(3));
                            mreq.wr_data = new_row;
                        end
                        up_next  = mid_reg;
                        mid_next = mem_rd_data;
                    end
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end

            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_alive_next = alive_reg;
                    rsp_op_next    = op_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rows_reg      <= CFG_W'(MAX_ROWS);
            cols_reg      <= CFG_W'(MAX_COLS);
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rows_reg      <= rows_next;
            cols_reg      <= cols_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        row_reg       <= row_next;
        col_reg       <= col_next;
        alive_reg     <= alive_next;
        up_reg        <= up_next;
        mid_reg       <= mid_next;
        row0_reg      <= row0_next;
        rsp_alive_reg <= rsp_alive_next;
        rsp_op_reg    <= rsp_op_next;
    end

endmodule
